### rtl/dpp_pkg.sv
// Shared constants and widths for the dynamic priority process picker.
// No dependencies; imported by dynamic_priority_process_picker.
package dpp_pkg;

  // Field widths
  localparam int unsigned PID_W   = 31;
  localparam int unsigned PRIO_W  = 7;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned NICE_W  = 4;

  // Division datapath: dividend is 10*sleep, divisor is sleep+run
  localparam int unsigned TOTAL_W = TICK_W + 1;
  localparam int unsigned DIV_W   = TICK_W + 4;
  localparam int unsigned QSTEPS  = NICE_W;

  // Packed word widths
  localparam int unsigned IN_DATA_W  = 144;
  localparam int unsigned OUT_DATA_W = 48;

  // Priority constants
  localparam logic [PRIO_W-1:0] MAX_DYN_PRIO = 7'd100;
  localparam logic [PRIO_W-1:0] PRIO_OFFSET  = 7'd5;
  localparam logic [NICE_W-1:0] NICE_SCALE   = 4'd10;

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;

endpackage

### rtl/dynamic_priority_process_picker.sv
// Dynamic priority process picker: niceness, dynamic priority and running pick.
// Depends on dpp_pkg (widths, constants, state codes).

// Takes one process record per input word and returns one result word for it.
// Each record passes through the accept cycle, four steps of a shared
// restoring divider that yields the niceness floor(10*sleep/(sleep+run)) one
// quotient bit per cycle, and a compare cycle that clamps the dynamic priority,
// updates the running pick and loads the output register. in_tready is high
// only while the sequencer is idle; a stalled output holds the compare cycle.
// On the record marked tlast the result carries the chosen pid (0 if no
// record was runnable) and the pick returns to priority 100, pid 0, count all
// ones. Input tuser carries the runnable flag, output tlast carries scan_done.
module dynamic_priority_process_picker
  import dpp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input record channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // proc_id[30:0], static_priority[37:31], sleep_ticks[69:38],
  // run_ticks[101:70], times_scheduled[133:102], prior_niceness[137:134], zeros
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,   // runnable
  input  logic                  in_tlast,   // last_entry
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // entry_niceness[3:0], entry_priority[10:4], chosen_pid[41:11], zeros
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast   // scan_done
);

  // Input field extraction
  logic [PID_W-1:0]   in_pid;
  logic [PRIO_W-1:0]  in_sprio;
  logic [TICK_W-1:0]  in_sleep;
  logic [TICK_W-1:0]  in_run;
  logic [COUNT_W-1:0] in_count;
  logic [NICE_W-1:0]  in_prior;
  logic [TOTAL_W-1:0] in_total;

  assign in_pid   = in_tdata[30:0];
  assign in_sprio = in_tdata[37:31];
  assign in_sleep = in_tdata[69:38];
  assign in_run   = in_tdata[101:70];
  assign in_count = in_tdata[133:102];
  assign in_prior = in_tdata[137:134];
  assign in_total = {1'b0, in_sleep} + {1'b0, in_run};

  // Sequencer and record registers
  logic [1:0]         state_r, state_nxt;
  logic [1:0]         step_r, step_nxt;
  logic               runnable_r;
  logic               last_r;
  logic               tzero_r;
  logic [PID_W-1:0]   pid_r;
  logic [PRIO_W-1:0]  sprio_r;
  logic [COUNT_W-1:0] count_r;
  logic [NICE_W-1:0]  prior_r;

  // Divider registers
  logic [DIV_W-1:0]   rem_r, rem_nxt;
  logic [DIV_W-1:0]   dvs_r, dvs_nxt;
  logic [NICE_W-1:0]  quo_r, quo_nxt;

  // Pick registers
  logic [PRIO_W-1:0]  best_prio_r, best_prio_nxt;
  logic [PID_W-1:0]   best_pid_r, best_pid_nxt;
  logic [COUNT_W-1:0] best_cnt_r, best_cnt_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;

  logic accept;
  logic out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Shared subtractor: trial subtract of the shifted divisor
  logic [DIV_W:0] trial;
  assign trial = {1'b0, rem_r} - {1'b0, dvs_r};

  // Compare-cycle logic: niceness select, clamp, pick update
  logic [NICE_W-1:0]  nice_sel;
  logic [PRIO_W:0]    biased;
  logic [PRIO_W+1:0]  diff;
  logic [PRIO_W-1:0]  dyn;
  logic               take_all;
  logic               take_tie;
  logic [PID_W-1:0]   pid_upd;

  always_comb begin
    nice_sel = (!runnable_r || tzero_r) ? prior_r : quo_r;
    biased   = {1'b0, sprio_r} + {1'b0, PRIO_OFFSET};
    diff     = {1'b0, biased} - {{(PRIO_W + 2 - NICE_W){1'b0}}, nice_sel};
    if (!runnable_r || diff[PRIO_W+1]) begin
      dyn = '0;
    end else if (diff[PRIO_W:0] > {1'b0, MAX_DYN_PRIO}) begin
      dyn = MAX_DYN_PRIO;
    end else begin
      dyn = diff[PRIO_W-1:0];
    end
    take_all = runnable_r && (dyn < best_prio_r);
    take_tie = runnable_r && (dyn == best_prio_r) && (count_r < best_cnt_r);
    pid_upd  = (take_all || take_tie) ? pid_r : best_pid_r;
  end

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    quo_nxt       = quo_r;
    best_prio_nxt = best_prio_r;
    best_pid_nxt  = best_pid_r;
    best_cnt_nxt  = best_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // dividend 10*sleep = 8*sleep + 2*sleep, divisor starts at total*8
          rem_nxt   = {1'b0, in_sleep, 3'b000} + {3'b000, in_sleep, 1'b0};
          dvs_nxt   = {in_total, 3'b000};
          quo_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // one quotient bit per cycle, MSB first
        if (!trial[DIV_W]) begin
          rem_nxt = trial[DIV_W-1:0];
        end
        quo_nxt  = {quo_r[NICE_W-2:0], !trial[DIV_W]};
        dvs_nxt  = {1'b0, dvs_r[DIV_W-1:1]};
        step_nxt = step_r + 2'd1;
        if (step_r == 2'(QSTEPS - 1)) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = last_r;
          out_data_nxt  = {{(OUT_DATA_W - PID_W - PRIO_W - NICE_W){1'b0}},
                           (last_r ? pid_upd : {PID_W{1'b0}}), dyn, nice_sel};
          if (last_r) begin
            best_prio_nxt = MAX_DYN_PRIO;
            best_pid_nxt  = '0;
            best_cnt_nxt  = '1;
          end else if (take_all) begin
            best_prio_nxt = dyn;
            best_pid_nxt  = pid_r;
            best_cnt_nxt  = count_r;
          end else if (take_tie) begin
            best_pid_nxt  = pid_r;
            best_cnt_nxt  = count_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      best_prio_r <= MAX_DYN_PRIO;
      best_pid_r  <= '0;
      best_cnt_r  <= '1;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      best_prio_r <= best_prio_nxt;
      best_pid_r  <= best_pid_nxt;
      best_cnt_r  <= best_cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    quo_r      <= quo_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    if (accept) begin
      runnable_r <= in_tuser;
      last_r     <= in_tlast;
      tzero_r    <= (in_total == '0);
      pid_r      <= in_pid;
      sprio_r    <= in_sprio;
      count_r    <= in_count;
      prior_r    <= in_prior;
    end
  end

  // Checks
  a_prio_range: assert property (@(posedge clk) disable iff (!rst_n)
    best_prio_r <= MAX_DYN_PRIO)
    else $error("held priority above maximum");

  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP && runnable_r && !tzero_r) |-> (quo_r <= NICE_SCALE))
    else $error("niceness quotient out of range");

  a_pid_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_data_r[41:11] == '0))
    else $error("chosen pid on a word that does not end a scan");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("ready right after accepting a record");

endmodule
